### src/sreu_pkg.sv
// Shared types, operation codes and sizing constants for the execute unit.
package sreu_pkg;

    // Default sizing handed to the top level
    localparam int DEF_MEM_WORDS = 1024;
    localparam int DEF_REG_COUNT = 32;

    // Fixed field widths of the transaction payloads
    localparam int FUNC_W      = 4;
    localparam int REG_NUM_W   = 5;
    localparam int REG_NUMS    = 1 << REG_NUM_W;
    localparam int WORD_ADDR_W = 10;
    localparam int DATA_W      = 32;
    // Widest word address over the supported memory sizes
    localparam int ADDR_MAX_W  = 16;

    // Operation table and program counter step
    localparam int NUM_OPS = 14;
    localparam logic [DATA_W-1:0] PC_STEP = 32'd4;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        OP_HALT  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_AND   = 4'd3,
        OP_OR    = 4'd4,
        OP_XOR   = 4'd5,
        OP_SLT   = 4'd6,
        OP_MUL   = 4'd7,
        OP_ADDI  = 4'd8,
        OP_LW    = 4'd9,
        OP_SW    = 4'd10,
        OP_BEQ   = 4'd11,
        OP_BNE   = 4'd12,
        OP_OTHER = 4'd13
    } op_t;

    // Instruction class picked by the front
    typedef enum logic [2:0] {
        CLS_HALT,
        CLS_ALU,
        CLS_LOAD,
        CLS_STORE,
        CLS_NOP
    } cls_t;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [REG_NUM_W-1:0]    dest_index;
        logic [REG_NUM_W-1:0]    src_a_index;
        logic [REG_NUM_W-1:0]    src_b_index;
        logic signed [DATA_W-1:0] immediate;
        logic [WORD_ADDR_W-1:0]  word_address;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]        pc_value;
        logic                     halted_flag;
        logic                     reg_written;
        logic [REG_NUM_W-1:0]     written_index;
        logic signed [DATA_W-1:0] written_value;
        logic                     mem_written;
        logic [DATA_W-1:0]        op_count;
    } out_item_t;

    // Classified instruction; register numbers and address already folded
    typedef struct packed {
        op_t                   op;
        cls_t                  cls;
        logic [REG_NUM_W-1:0]  rd;
        logic [REG_NUM_W-1:0]  ra;
        logic [REG_NUM_W-1:0]  rb;
        logic [DATA_W-1:0]     imm;
        logic [ADDR_MAX_W-1:0] addr;
    } exec_t;

endpackage

### src/sreu_front.sv
// Front end: accepts instructions, folds indexes and addresses, classifies.
module sreu_front import sreu_pkg::*; #(
    parameter int MEM_WORDS = DEF_MEM_WORDS,
    parameter int REG_COUNT = DEF_REG_COUNT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     hold,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output exec_t    q_data
);

    // Address fold by reciprocal: exact for every 10-bit address
    localparam int DIV_SHIFT = WORD_ADDR_W + 17;
    localparam logic [DATA_W-1:0] RECIP =
        DATA_W'(((64'd1 << DIV_SHIFT) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));
    localparam int PROD_W = WORD_ADDR_W + DATA_W;

    logic                     f_valid_reg;
    logic                     f_valid_next;
    in_item_t                 f_item_reg;
    logic [WORD_ADDR_W-1:0]   f_quot_reg;
    logic [PROD_W-1:0]        quot_prod;
    logic [DATA_W-1:0]        rem_full;
    logic [REG_NUM_W-1:0]     rmap [REG_NUMS];
    op_t                      op_norm;
    cls_t                     cls;
    logic                     accept;

    // Register number fold table, worked out at elaboration
    for (genvar i = 0; i < REG_NUMS; i++) begin : g_rmap
        localparam int MAPPED = i % REG_COUNT;
        assign rmap[i] = REG_NUM_W'(MAPPED);
    end

    assign accept  = s_valid && s_ready;
    assign s_ready = !hold && (!f_valid_reg || !q_full);
    assign q_push  = f_valid_reg && !q_full;

    // Quotient of the word address, registered before the remainder step
    assign quot_prod = PROD_W'(s_data.word_address) * PROD_W'(RECIP);

    always_comb begin
        f_valid_next = f_valid_reg;
        if (accept) begin
            f_valid_next = 1'b1;
        end else if (q_push) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
        if (accept) begin
            f_item_reg <= s_data;
            f_quot_reg <= quot_prod[DIV_SHIFT +: WORD_ADDR_W];
        end
    end

    // Remainder of the word address
    assign rem_full = DATA_W'(f_item_reg.word_address)
                    - DATA_W'(f_quot_reg) * DATA_W'(MEM_WORDS);

    // Fold unused operation codes and classify
    always_comb begin
        if (f_item_reg.func >= FUNC_W'(NUM_OPS)) begin
            op_norm = OP_OTHER;
        end else begin
            op_norm = op_t'(f_item_reg.func);
        end
        case (op_norm)
            OP_HALT: begin
                cls = CLS_HALT;
            end
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SLT, OP_MUL, OP_ADDI: begin
                cls = CLS_ALU;
            end
            OP_LW: begin
                cls = CLS_LOAD;
            end
            OP_SW: begin
                cls = CLS_STORE;
            end
            default: begin
                cls = CLS_NOP;
            end
        endcase
    end

    always_comb begin
        q_data.op   = op_norm;
        q_data.cls  = cls;
        q_data.rd   = rmap[f_item_reg.dest_index];
        q_data.ra   = rmap[f_item_reg.src_a_index];
        q_data.rb   = rmap[f_item_reg.src_b_index];
        q_data.imm  = f_item_reg.immediate;
        q_data.addr = rem_full[ADDR_MAX_W-1:0];
    end

endmodule

### src/sreu_queue.sv
// Short queue of classified instructions between front and back.
module sreu_queue import sreu_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  exec_t push_data,
    input  logic  pop,
    output logic  full,
    output logic  not_empty,
    output exec_t head
);

    exec_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and hold the entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/sreu_back.sv
// Back end: register file, data memory, execute stage and result register.
module sreu_back import sreu_pkg::*; #(
    parameter int MEM_WORDS = DEF_MEM_WORDS,
    parameter int REG_COUNT = DEF_REG_COUNT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  exec_t     q_data,
    output logic      q_pop,
    output logic      clearing,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int AW     = $clog2(MEM_WORDS);
    localparam int RIDX_W = $clog2(REG_COUNT);

    // Storage
    logic [DATA_W-1:0]    rf_a_mem [REG_COUNT];
    logic [DATA_W-1:0]    rf_b_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [DATA_W-1:0]    dm_mem [MEM_WORDS];
    logic [DATA_W-1:0]    op_cnt_reg [NUM_OPS];

    // Read data captured when an instruction enters execute
    logic [DATA_W-1:0] rf_a_rdata_reg;
    logic [DATA_W-1:0] rf_b_rdata_reg;
    logic [DATA_W-1:0] rf_d_rdata_reg;
    logic [DATA_W-1:0] dm_rdata_reg;
    logic              a_vld_reg;
    logic              b_vld_reg;
    logic              d_vld_reg;

    // Execute stage
    logic  x_valid_reg;
    exec_t x_item_reg;
    logic  x_load;
    logic  x_retire;

    // Bypass of the write that landed as this instruction read
    logic                  fwd_rf_valid_reg;
    logic [REG_NUM_W-1:0]  fwd_rf_idx_reg;
    logic [DATA_W-1:0]     fwd_rf_val_reg;
    logic                  fwd_dm_valid_reg;
    logic [ADDR_MAX_W-1:0] fwd_dm_addr_reg;
    logic [DATA_W-1:0]     fwd_dm_val_reg;

    // Architectural state and result register
    logic [DATA_W-1:0] pc_reg;
    logic [DATA_W-1:0] pc_next;
    logic              halt_reg;
    logic              halt_next;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    // Memory clearing pass after reset
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // Execute datapath
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic [DATA_W-1:0] opd;
    logic [DATA_W-1:0] ld_data;
    logic [DATA_W-1:0] alu_val;
    logic [DATA_W-1:0] wr_val;
    logic [DATA_W-1:0] cnt_next;
    logic              rd_zero;
    logic              ret_wr;
    logic              ret_mw;
    logic              ret_adv;
    out_item_t         result;

    assign clearing = clr_active_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign x_retire = x_valid_reg && (!m_valid_reg || m_ready);
    assign x_load   = q_valid && !clr_active_reg && (!x_valid_reg || x_retire);
    assign q_pop    = x_load;

    // Operand select with bypass
    always_comb begin
        if (fwd_rf_valid_reg && fwd_rf_idx_reg == x_item_reg.ra) begin
            opa = fwd_rf_val_reg;
        end else begin
            opa = a_vld_reg ? rf_a_rdata_reg : '0;
        end
        if (fwd_rf_valid_reg && fwd_rf_idx_reg == x_item_reg.rb) begin
            opb = fwd_rf_val_reg;
        end else begin
            opb = b_vld_reg ? rf_b_rdata_reg : '0;
        end
        if (fwd_rf_valid_reg && fwd_rf_idx_reg == x_item_reg.rd) begin
            opd = fwd_rf_val_reg;
        end else begin
            opd = d_vld_reg ? rf_d_rdata_reg : '0;
        end
        if (fwd_dm_valid_reg && fwd_dm_addr_reg == x_item_reg.addr) begin
            ld_data = fwd_dm_val_reg;
        end else begin
            ld_data = dm_rdata_reg;
        end
    end

    // Arithmetic and logic unit
    always_comb begin
        case (x_item_reg.op)
            OP_ADD:  alu_val = opa + opb;
            OP_SUB:  alu_val = opa - opb;
            OP_AND:  alu_val = opa & opb;
            OP_OR:   alu_val = opa | opb;
            OP_XOR:  alu_val = opa ^ opb;
            OP_SLT:  alu_val = ($signed(opa) < $signed(opb)) ? DATA_W'(1) : '0;
            OP_MUL:  alu_val = opa * opb;
            OP_ADDI: alu_val = opa + x_item_reg.imm;
            default: alu_val = '0;
        endcase
    end

    // Effects of the instruction in execute
    always_comb begin
        rd_zero = (x_item_reg.rd == '0);
        ret_wr  = 1'b0;
        ret_mw  = 1'b0;
        ret_adv = 1'b1;
        wr_val  = '0;
        case (x_item_reg.cls)
            CLS_HALT: begin
                ret_adv = 1'b0;
            end
            CLS_ALU: begin
                ret_wr  = !rd_zero;
                ret_adv = !rd_zero;
                wr_val  = rd_zero ? '0 : alu_val;
            end
            CLS_LOAD: begin
                ret_wr = !rd_zero;
                wr_val = rd_zero ? '0 : ld_data;
            end
            CLS_STORE: begin
                ret_mw = 1'b1;
            end
            default: begin
                ret_adv = 1'b1;
            end
        endcase
        pc_next   = pc_reg + (ret_adv ? PC_STEP : '0);
        halt_next = halt_reg || (x_item_reg.cls == CLS_HALT);
        cnt_next  = op_cnt_reg[x_item_reg.op] + 1'b1;

        result.pc_value      = pc_next;
        result.halted_flag   = halt_next;
        result.reg_written   = ret_wr;
        result.written_index = ret_wr ? x_item_reg.rd : '0;
        result.written_value = wr_val;
        result.mem_written   = ret_mw;
        result.op_count      = cnt_next;
    end

    // Register file copies: write on retire, read on entry to execute
    always_ff @(posedge aclk) begin
        if (x_retire && ret_wr) begin
            rf_a_mem[x_item_reg.rd[RIDX_W-1:0]] <= wr_val;
        end
        if (x_load) begin
            rf_a_rdata_reg <= rf_a_mem[q_data.ra[RIDX_W-1:0]];
            rf_b_rdata_reg <= rf_a_mem[q_data.rb[RIDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (x_retire && ret_wr) begin
            rf_b_mem[x_item_reg.rd[RIDX_W-1:0]] <= wr_val;
        end
        if (x_load) begin
            rf_d_rdata_reg <= rf_b_mem[q_data.rd[RIDX_W-1:0]];
        end
    end

    // Data memory: clearing pass, then stores on retire and loads on entry
    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            dm_mem[clr_addr_reg] <= '0;
        end else if (x_retire && ret_mw) begin
            dm_mem[x_item_reg.addr[AW-1:0]] <= opd;
        end
        if (x_load) begin
            dm_rdata_reg <= dm_mem[q_data.addr[AW-1:0]];
        end
    end

    // Execute stage payload and bypass capture
    always_ff @(posedge aclk) begin
        if (x_load) begin
            x_item_reg     <= q_data;
            a_vld_reg      <= rf_valid_reg[q_data.ra[RIDX_W-1:0]];
            b_vld_reg      <= rf_valid_reg[q_data.rb[RIDX_W-1:0]];
            d_vld_reg      <= rf_valid_reg[q_data.rd[RIDX_W-1:0]];
            fwd_rf_idx_reg <= x_item_reg.rd;
            fwd_rf_val_reg <= wr_val;
            fwd_dm_addr_reg <= x_item_reg.addr;
            fwd_dm_val_reg <= opd;
        end
        if (x_retire) begin
            m_data_reg <= result;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            fwd_rf_valid_reg <= 1'b0;
            fwd_dm_valid_reg <= 1'b0;
            rf_valid_reg     <= '0;
            pc_reg           <= '0;
            halt_reg         <= 1'b0;
            clr_active_reg   <= 1'b1;
            clr_addr_reg     <= '0;
            for (int i = 0; i < NUM_OPS; i++) begin
                op_cnt_reg[i] <= '0;
            end
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(MEM_WORDS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (x_load) begin
                x_valid_reg      <= 1'b1;
                fwd_rf_valid_reg <= x_retire && ret_wr;
                fwd_dm_valid_reg <= x_retire && ret_mw;
            end else if (x_retire) begin
                x_valid_reg <= 1'b0;
            end
            if (x_retire) begin
                m_valid_reg <= 1'b1;
                pc_reg      <= pc_next;
                halt_reg    <= halt_next;
                op_cnt_reg[x_item_reg.op] <= cnt_next;
                if (ret_wr) begin
                    rf_valid_reg[x_item_reg.rd[RIDX_W-1:0]] <= 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### src/simple_risc_execute_unit.sv
// Top level of the execute unit: front end, queue and back end.
//
// Executes one decoded instruction per transaction and returns one result per
// transaction, in order. Sustained rate is one instruction per clock while the
// output is not stalled: the front takes an instruction every cycle while the
// queue has room, and the back retires one per cycle while m_ready allows it,
// through a single execute stage that reads the register file and data memory
// as the instruction enters execute and bypasses the write of the instruction
// just retired. The accepting edge loads the front register; the instruction
// then passes the queue write, the operand read and the execute step into the
// result register, where a valid result appears. After reset the data memory
// is swept to zero, one word per cycle, and s_ready stays low for the sweep.
module simple_risc_execute_unit import sreu_pkg::*; #(
    parameter int MEM_WORDS = DEF_MEM_WORDS,
    parameter int REG_COUNT = DEF_REG_COUNT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic  clearing;
    logic  q_full;
    logic  q_push;
    exec_t q_push_data;
    logic  q_pop;
    logic  q_not_empty;
    exec_t q_head;

    // Accept and classify
    sreu_front #(
        .MEM_WORDS (MEM_WORDS),
        .REG_COUNT (REG_COUNT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .hold    (clearing),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_push_data)
    );

    // Decouple front and back
    sreu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Execute and deliver results
    sreu_back #(
        .MEM_WORDS (MEM_WORDS),
        .REG_COUNT (REG_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_data   (q_head),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
